// ----- rtl/core/comfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center-of-mass frame shift: shared definitions
// Default sizes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package comfs_pkg;

  localparam int MaxParticlesDef = 64;
  localparam int PosWidthDef     = 24;
  localparam int MassWidthDef    = 16;

  typedef struct packed {
    logic load;       // An input transaction is taken this cycle.
    logic div_init;   // Load the dividers from the finished sums.
    logic div_step;   // One quotient bit on every axis.
    logic fin;        // Fix the signed center.
    logic issue;      // Read the next buffered particle.
    logic consume;    // Move the read particle into the output register.
    logic out_pop;    // The output transaction completes this cycle.
    logic clear;      // Start a new set.
  } cmd_t;

  typedef struct packed {
    logic more;       // Buffered particles remain to be read.
    logic pend;       // Read data waits for the output register.
    logic out_valid;  // The output register holds a result.
  } sts_t;

endpackage

// ----- rtl/core/comfs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center-of-mass frame shift: controller
// Sequences loading, the final accumulate, the bit-serial division and the
// emission pass, and drives the handshakes.
// ----------------------------------------------------------------------------
module comfs_ctrl #(
  parameter int MAX_PARTICLES = comfs_pkg::MaxParticlesDef,
  parameter int POS_WIDTH     = comfs_pkg::PosWidthDef,
  parameter int MASS_WIDTH    = comfs_pkg::MassWidthDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            s_tlast,
  input  logic            m_tready,
  input  comfs_pkg::sts_t sts,
  output comfs_pkg::cmd_t cmd
);
  import comfs_pkg::*;

  localparam int CntW = $clog2(MAX_PARTICLES + 1);
  localparam int AccW = POS_WIDTH + MASS_WIDTH + CntW;
  localparam int DcW  = $clog2(AccW);

  typedef enum logic [2:0] {
    LOAD,
    FLUSH,
    PREP,
    DIV,
    FIN,
    EMIT
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [DcW-1:0] div_cnt;
  logic          in_acc;
  logic          out_free;

  assign s_tready = (state == LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !sts.out_valid || m_tready;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    cmd.out_pop = sts.out_valid && m_tready;
    case (state)
      LOAD: begin
        cmd.load = in_acc;
        if (in_acc && s_tlast) begin
          state_next = FLUSH;
        end
      end
      FLUSH: begin
        state_next = PREP;
      end
      PREP: begin
        cmd.div_init = 1'b1;
        state_next   = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == '0) begin
          state_next = FIN;
        end
      end
      FIN: begin
        cmd.fin    = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        cmd.consume = sts.pend && out_free;
        cmd.issue   = sts.more && (!sts.pend || cmd.consume);
        if (!sts.more && !sts.pend) begin
          cmd.clear  = 1'b1;
          state_next = LOAD;
        end
      end
      default: begin
        state_next = LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == PREP) begin
        div_cnt <= DcW'(AccW - 1);
      end else if (state == DIV) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/comfs_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center-of-mass frame shift: datapath
// Particle buffer, weighted sums, three restoring dividers, and the
// subtract stage with its output register.
// ----------------------------------------------------------------------------
module comfs_dpath #(
  parameter int MAX_PARTICLES = comfs_pkg::MaxParticlesDef,
  parameter int POS_WIDTH     = comfs_pkg::PosWidthDef,
  parameter int MASS_WIDTH    = comfs_pkg::MassWidthDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  comfs_pkg::cmd_t             cmd,
  output comfs_pkg::sts_t             sts,
  input  logic        [MASS_WIDTH-1:0] mass,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic        [POS_WIDTH-1:0] smoothing,
  output logic                        out_valid,
  output logic signed [POS_WIDTH:0]   shifted_x,
  output logic signed [POS_WIDTH:0]   shifted_y,
  output logic signed [POS_WIDTH:0]   shifted_z,
  output logic        [POS_WIDTH-1:0] smoothing_out,
  output logic                        last_out,
  output logic                        zero_mass,
  output logic                        overflowed
);
  import comfs_pkg::*;

  localparam int CntW  = $clog2(MAX_PARTICLES + 1);
  localparam int IdxW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int AccW  = POS_WIDTH + MASS_WIDTH + CntW;
  localparam int MtW   = MASS_WIDTH + CntW;
  localparam int ProdW = POS_WIDTH + MASS_WIDTH + 1;
  localparam int EntW  = 4 * POS_WIDTH;

  logic [EntW-1:0]          store [MAX_PARTICLES];
  logic [EntW-1:0]          rd_data;
  logic [CntW-1:0]          cnt;
  logic [CntW-1:0]          rd_idx;
  logic                     pend;
  logic                     pend_last;
  logic [MtW-1:0]           mt;
  logic                     ovf;
  logic                     zm;
  logic                     prod_v;
  logic signed [ProdW-1:0]  prod [3];
  logic signed [AccW-1:0]   sum [3];
  logic [AccW-1:0]          num [3];
  logic [MtW-1:0]           rem [3];
  logic                     neg [3];
  logic signed [POS_WIDTH:0] center [3];
  logic [MtW:0]             rem_sh [3];
  logic                     qbit [3];
  logic [MtW-1:0]           rem_next [3];
  logic signed [POS_WIDTH-1:0] pos_in [3];
  logic signed [POS_WIDTH-1:0] rd_pos [3];
  logic                     room;

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign rd_pos[0] = rd_data[POS_WIDTH-1:0];
  assign rd_pos[1] = rd_data[2*POS_WIDTH-1:POS_WIDTH];
  assign rd_pos[2] = rd_data[3*POS_WIDTH-1:2*POS_WIDTH];
  assign room      = (cnt < CntW'(MAX_PARTICLES));

  assign sts.more      = (rd_idx < cnt);
  assign sts.pend      = pend;
  assign sts.out_valid = out_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i], num[i][AccW-1]};
      qbit[i]   = (rem_sh[i] >= {1'b0, mt});
      if (qbit[i]) begin
        rem_next[i] = MtW'(rem_sh[i] - {1'b0, mt});
      end else begin
        rem_next[i] = rem_sh[i][MtW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      store[cnt[IdxW-1:0]] <= {smoothing, pos_z, pos_y, pos_x};
    end
    if (cmd.issue) begin
      rd_data <= store[rd_idx[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= $signed({1'b0, mass}) * pos_in[i];
      end
    end
    if (cmd.div_init) begin
      zm <= (mt == '0);
      for (int i = 0; i < 3; i++) begin
        neg[i] <= sum[i][AccW-1];
        num[i] <= sum[i][AccW-1] ? AccW'(-sum[i]) : AccW'(sum[i]);
        rem[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= {num[i][AccW-2:0], qbit[i]};
        rem[i] <= rem_next[i];
      end
    end
    if (cmd.fin) begin
      for (int i = 0; i < 3; i++) begin
        if (zm) begin
          center[i] <= '0;
        end else if (neg[i]) begin
          center[i] <= -$signed(num[i][POS_WIDTH:0]);
        end else begin
          center[i] <= $signed(num[i][POS_WIDTH:0]);
        end
      end
    end
    if (cmd.issue) begin
      pend_last <= (rd_idx == cnt - 1'b1);
    end
    if (cmd.consume) begin
      shifted_x     <= {rd_pos[0][POS_WIDTH-1], rd_pos[0]} - center[0];
      shifted_y     <= {rd_pos[1][POS_WIDTH-1], rd_pos[1]} - center[1];
      shifted_z     <= {rd_pos[2][POS_WIDTH-1], rd_pos[2]} - center[2];
      smoothing_out <= rd_data[EntW-1:3*POS_WIDTH];
      last_out      <= pend_last;
      zero_mass     <= zm;
      overflowed    <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt    <= '0;
      rd_idx <= '0;
      mt     <= '0;
      ovf    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        if (room) begin
          cnt <= cnt + 1'b1;
          mt  <= mt + MtW'(mass);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (prod_v) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= sum[i] + AccW'(prod[i]);
        end
      end
      if (cmd.issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      prod_v <= cmd.load && room;
      pend   <= cmd.issue || (pend && !cmd.consume);
      if (cmd.consume) begin
        out_valid <= 1'b1;
      end else if (cmd.out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(MAX_PARTICLES))
    else $error("Particle count exceeds the buffer depth.");

  a_issue_in_set: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> rd_idx < cnt)
    else $error("Read issued past the buffered particles.");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.consume))
    else $error("Output became valid without read data.");

endmodule

// ----- rtl/core/center_of_mass_frame_shift_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center-of-mass frame shift unit
// Buffers a set of particles, finds their center of mass and emits every
// particle moved into the center-of-mass frame.
// ----------------------------------------------------------------------------
// Particles are taken one per cycle while loading. The transaction with tlast
// closes the set: the last product is accumulated, the dividers are set up,
// and three restoring dividers produce the center one quotient bit per cycle;
// a final step fixes the sign. After that the buffered particles are read
// from the buffer memory, each read registered before it enters the output
// register, and emitted at one per cycle while the sink is ready; then the
// set is cleared. No input is taken from the closing transaction until the
// last result has entered the output register. Particles past MAX_PARTICLES
// are dropped and flag every result of the set; a set with zero total mass is
// passed through unshifted with its flag set.
module center_of_mass_frame_shift_unit #(
  parameter int MAX_PARTICLES = comfs_pkg::MaxParticlesDef,
  parameter int POS_WIDTH     = comfs_pkg::PosWidthDef,
  parameter int MASS_WIDTH    = comfs_pkg::MassWidthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // mass, pos_x, pos_y, pos_z, smoothing
  input  logic [((MASS_WIDTH + 4 * POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // shifted_x, shifted_y, shifted_z, smoothing_out
  output logic [((4 * POS_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic m_tlast,
  // zero_mass, overflowed
  output logic [1:0] m_tuser
);
  import comfs_pkg::*;

  localparam int OutDw = ((4 * POS_WIDTH + 3 + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  logic        [MASS_WIDTH-1:0] mass;
  logic signed [POS_WIDTH-1:0]  pos_x;
  logic signed [POS_WIDTH-1:0]  pos_y;
  logic signed [POS_WIDTH-1:0]  pos_z;
  logic        [POS_WIDTH-1:0]  smoothing;
  logic signed [POS_WIDTH:0]    shifted_x;
  logic signed [POS_WIDTH:0]    shifted_y;
  logic signed [POS_WIDTH:0]    shifted_z;
  logic        [POS_WIDTH-1:0]  smoothing_out;
  logic                         zero_mass;
  logic                         overflowed;

  assign mass      = s_tdata[MASS_WIDTH-1:0];
  assign pos_x     = s_tdata[MASS_WIDTH +: POS_WIDTH];
  assign pos_y     = s_tdata[MASS_WIDTH + POS_WIDTH +: POS_WIDTH];
  assign pos_z     = s_tdata[MASS_WIDTH + 2 * POS_WIDTH +: POS_WIDTH];
  assign smoothing = s_tdata[MASS_WIDTH + 3 * POS_WIDTH +: POS_WIDTH];

  assign m_tdata = OutDw'({smoothing_out, shifted_z, shifted_y, shifted_x});
  assign m_tuser = {overflowed, zero_mass};

  comfs_ctrl #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .POS_WIDTH    (POS_WIDTH),
    .MASS_WIDTH   (MASS_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  comfs_dpath #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .POS_WIDTH    (POS_WIDTH),
    .MASS_WIDTH   (MASS_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mass         (mass),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .smoothing    (smoothing),
    .out_valid    (m_tvalid),
    .shifted_x    (shifted_x),
    .shifted_y    (shifted_y),
    .shifted_z    (shifted_z),
    .smoothing_out(smoothing_out),
    .last_out     (m_tlast),
    .zero_mass    (zero_mass),
    .overflowed   (overflowed)
  );

endmodule

// ----- bench/center_of_mass_frame_shift_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center-of-mass frame shift unit testbench
// Streams particle sets through the unit and predicts every shifted particle
// from a behavioral copy of the set buffer, the weighted sums and the
// truncating divide. Both stream sides idle at random, the sink holds off
// once for a long stretch and the source waits twice for a full drain.
// ----------------------------------------------------------------------------
module center_of_mass_frame_shift_unit_tb;

  localparam int MaxParticles = comfs_pkg::MaxParticlesDef;
  localparam int PosW         = comfs_pkg::PosWidthDef;
  localparam int MassW        = comfs_pkg::MassWidthDef;
  localparam int InW          = ((MassW + 4 * PosW + 7) / 8) * 8;
  localparam int OutW         = ((4 * PosW + 3 + 7) / 8) * 8;
  localparam int ShW          = PosW + 1;
  localparam int IdleLimit    = 3000;
  localparam int HoldCycles   = 400;
  localparam logic [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  typedef struct {
    logic [MassW-1:0]       mass;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic [PosW-1:0]        h;
    logic                   last;
  } particle_t;

  typedef struct {
    logic signed [ShW-1:0] x;
    logic signed [ShW-1:0] y;
    logic signed [ShW-1:0] z;
    logic [PosW-1:0]       h;
    logic                  last;
    logic                  zero_mass;
    logic                  overflowed;
  } shifted_t;

  class com_shift_scoreboard;
    logic signed [PosW-1:0] xs [MaxParticles];
    logic signed [PosW-1:0] ys [MaxParticles];
    logic signed [PosW-1:0] zs [MaxParticles];
    logic [PosW-1:0]        hs [MaxParticles];
    longint   sum_mx;
    longint   sum_my;
    longint   sum_mz;
    longint   mass_total;
    int       count;
    bit       dropped;
    shifted_t expected_shifts[$];
    int       errors;

    function new();
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      sum_mx = 0;
      sum_my = 0;
      sum_mz = 0;
      mass_total = 0;
      count = 0;
      dropped = 0;
    endfunction

    function void note_input(particle_t p);
      longint   cx;
      longint   cy;
      longint   cz;
      shifted_t r;
      if (count < MaxParticles) begin
        xs[count] = p.x;
        ys[count] = p.y;
        zs[count] = p.z;
        hs[count] = p.h;
        sum_mx += longint'(p.mass) * longint'(p.x);
        sum_my += longint'(p.mass) * longint'(p.y);
        sum_mz += longint'(p.mass) * longint'(p.z);
        mass_total += longint'(p.mass);
        count++;
      end else begin
        dropped = 1;
      end
      if (!p.last) return;
      cx = 0;
      cy = 0;
      cz = 0;
      if (mass_total != 0) begin
        cx = sum_mx / mass_total;
        cy = sum_my / mass_total;
        cz = sum_mz / mass_total;
      end
      for (int k = 0; k < count; k++) begin
        r.x = ShW'(longint'(xs[k]) - cx);
        r.y = ShW'(longint'(ys[k]) - cy);
        r.z = ShW'(longint'(zs[k]) - cz);
        r.h = hs[k];
        r.last = (k == count - 1);
        r.zero_mass = (mass_total == 0);
        r.overflowed = dropped;
        expected_shifts.push_back(r);
      end
      clear_set();
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutW-1:0] data, logic last, logic [1:0] user);
      shifted_t e;
      if (expected_shifts.size() == 0) begin
        $display("%0t unexpected result: actual %0h", $time, data);
        errors++;
        return;
      end
      e = expected_shifts.pop_front();
      field_check("shifted_x", longint'(e.x), longint'($signed(data[ShW-1:0])));
      field_check("shifted_y", longint'(e.y), longint'($signed(data[2*ShW-1:ShW])));
      field_check("shifted_z", longint'(e.z), longint'($signed(data[3*ShW-1:2*ShW])));
      field_check("smoothing_out", e.h, data[3*ShW+PosW-1:3*ShW]);
      field_check("padding", 0, data[OutW-1:3*ShW+PosW]);
      field_check("last_out", e.last, last);
      field_check("zero_mass", e.zero_mass, user[0]);
      field_check("overflowed", e.overflowed, user[1]);
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [InW-1:0]  s_tdata;
  logic            s_tlast;
  logic            m_tvalid;
  logic            m_tready;
  logic [OutW-1:0] m_tdata;
  logic            m_tlast;
  logic [1:0]      m_tuser;

  com_shift_scoreboard board;
  int results_seen;
  bit hold_done;
  int idle_cycles;

  center_of_mass_frame_shift_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic particle_t make_particle(logic [MassW-1:0] mass, logic [PosW-1:0] x,
                                              logic [PosW-1:0] y, logic [PosW-1:0] z,
                                              logic [PosW-1:0] h, logic last);
    particle_t p;
    p.mass = mass;
    p.x = x;
    p.y = y;
    p.z = z;
    p.h = h;
    p.last = last;
    return p;
  endfunction

  task automatic send_particle(particle_t p);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {p.h, p.z, p.y, p.x, p.mass};
    s_tlast <= p.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_input(p);
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (board.expected_shifts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [MassW-1:0] pick_mass();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return MassW'($urandom);
    endcase
  endfunction

  task automatic send_set(int n);
    bit massless;
    massless = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      send_particle(make_particle(massless ? '0 : pick_mass(), PosW'($urandom),
                                  PosW'($urandom), PosW'($urandom), PosW'($urandom),
                                  i == n - 1));
    end
  endtask

  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 120) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1;
      end else begin
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_result(m_tdata, m_tlast, m_tuser);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("center_of_mass_frame_shift_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int set_no;
    int n;
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    results_seen = 0;
    hold_done = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extreme masses and positions in one set.
    send_particle(make_particle('1, PosMax, PosMin, '0, '1, 1'b0));
    send_particle(make_particle('1, PosMin, PosMax, '1, '0, 1'b0));
    send_particle(make_particle(16'd1, 24'sd1, -24'sd1, PosMax, 24'h5a5a5a, 1'b1));
    // A set whose total mass is zero is passed through unshifted.
    send_particle(make_particle('0, 24'h123456, PosMin, PosMax, 24'h0f0f0f, 1'b0));
    send_particle(make_particle('0, -24'sd77, 24'h000001, PosMin, 24'ha5a5a5, 1'b1));
    // Single particles, with and without mass.
    send_particle(make_particle('1, PosMin, PosMin, PosMin, '1, 1'b1));
    send_particle(make_particle('0, PosMax, PosMax, PosMax, '0, 1'b1));
    // Small centers, negative on x and z, exercise truncation toward zero.
    send_particle(make_particle(16'd3, -24'sd10, 24'sd7, -24'sd1, 24'h000100, 1'b0));
    send_particle(make_particle(16'd3, -24'sd1, 24'sd2, -24'sd5, 24'h000200, 1'b0));
    send_particle(make_particle(16'd1, 24'sd4, -24'sd9, 24'sd3, 24'h000300, 1'b0));
    send_particle(make_particle(16'd5, -24'sd3, 24'sd1, -24'sd2, 24'h000400, 1'b1));
    // Mixed signs, with one particle at full weight.
    send_particle(make_particle('1, PosMax, PosMax, PosMin, 24'h800000, 1'b0));
    send_particle(make_particle(16'd1, PosMin, PosMin, PosMax, 24'h7fffff, 1'b1));
    wait_drained();

    sent = 0;
    set_no = 0;
    while (sent < 330) begin
      if (set_no == 3) n = MaxParticles;
      else if (set_no == 8) n = $urandom_range(MaxParticles + 1, MaxParticles + 8);
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(9, 32);
      else n = $urandom_range(1, 8);
      send_set(n);
      sent += n;
      set_no++;
      if (set_no == 12) wait_drained();
    end
    idle_input();

    while (board.expected_shifts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.expected_shifts.size() == 0) begin
      $display("center_of_mass_frame_shift_unit_tb passed");
    end else begin
      $display("center_of_mass_frame_shift_unit_tb failed");
    end
    $finish;
  end

endmodule
